FILE: design/p2x_pkg.sv
// Shared types, codes and pixel arithmetic for the 2x pixel-art upscaler.
package p2x_pkg;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_CLAMP_HORIZ  = 2'd2;
	localparam cfg_idx_t CFG_CLAMP_VERT   = 2'd3;

	// Input command codes
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_PROCESS = 1'b1;

	// Reset sizes
	localparam logic [10:0] SIDE_RESET = 11'd64;

	// Averaging masks, 8888 layout
	localparam logic [31:0] HI1_MASK = 32'hFEFE_FEFE;
	localparam logic [31:0] LO1_MASK = 32'h0101_0101;
	localparam logic [31:0] HI2_MASK = 32'hFCFC_FCFC;
	localparam logic [31:0] LO2_MASK = 32'h0303_0303;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_EVAL   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	// Pixel equalities of the 4x4 window; c = k11, r = k12, d = k21, e = k22
	typedef struct packed {
		logic ce;
		logic rd;
		logic cr;
		logic cd;
		logic de;
		logic re;
		logic c00;
		logic c01;
		logic c02;
		logic c10;
		logic c13;
		logic c20;
		logic c23;
		logic c31;
		logic c32;
		logic r01;
		logic r02;
		logic r03;
		logic r10;
		logic r13;
		logic r20;
		logic r23;
		logic r31;
		logic r32;
		logic d10;
		logic d20;
		logic d30;
		logic d32;
	} eq_t;

	function automatic logic [31:0] avg2(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] sum;
		sum = ((a & HI1_MASK) >> 1) + ((b & HI1_MASK) >> 1);
		if (a == b) begin
			return a;
		end
		return sum | (a & b & LO1_MASK);
	endfunction

	function automatic logic [31:0] avg4(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] hi;
		logic [31:0] lo;
		hi = ((a & HI2_MASK) >> 2) + ((b & HI2_MASK) >> 2) +
			((c & HI2_MASK) >> 2) + ((d & HI2_MASK) >> 2);
		lo = (((a & LO2_MASK) + (b & LO2_MASK) + (c & LO2_MASK) + (d & LO2_MASK)) >> 2)
			& LO2_MASK;
		return hi | lo;
	endfunction

	// Weighs neighbours s and t towards p (+1) or q (-1), from equality flags
	function automatic logic signed [3:0] vote(input logic ps, input logic qs,
			input logic pt, input logic qt);
		logic [1:0] np;
		logic [1:0] nq;
		logic signed [3:0] res;
		np  = {1'b0, ps} + {1'b0, pt};
		nq  = {1'b0, !ps && qs} + {1'b0, !pt && qt};
		res = 4'sd0;
		if (np <= 2'd1) begin
			res = res + 4'sd1;
		end
		if (nq <= 2'd1) begin
			res = res - 4'sd1;
		end
		return res;
	endfunction

	// Neighbour at offset k-1 along an axis of n pixels; pos < n, n >= 1
	function automatic logic [10:0] neighbour(input logic [10:0] pos, input logic [1:0] k,
			input logic [10:0] n, input logic clamp);
		logic [12:0] s;
		logic [12:0] t;
		logic [12:0] n_x;
		s   = {2'b00, pos} + {11'd0, k};
		n_x = {2'b00, n};
		t   = s - 13'd1;
		if (clamp) begin
			if (s == 13'd0) begin
				t = 13'd0;
			end else if (t > n_x - 13'd1) begin
				t = n_x - 13'd1;
			end
		end else begin
			if (s == 13'd0) begin
				t = n_x - 13'd1;
			end else begin
				if (t >= n_x) begin
					t = t - n_x;
				end
				if (t >= n_x) begin
					t = t - n_x;
				end
			end
		end
		return t[10:0];
	endfunction

endpackage

FILE: design/p2x_ram.sv
// Generic single-port RAM with registered read.
module p2x_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: design/pixel_art_2x_upscaler.sv
// Top level of the 2xSaI pixel-art upscaler with its RGBA8888 frame store.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tuser: cmd; tdata: index, value, x, y
//  m_axis   | out       | m_axis_tvalid/tready   | tuser: range_error; tdata: four pixels
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data (four registers)
//
// Flow: a write request is taken on its handshake. A process request holds the input for
//   16 reads of the single-port frame store, one per window pixel, a drain of the address
//   and read-data stages, one compare-and-average step and one select step. A range-error
//   request skips the reads and goes straight to the select step.
// Stalls: the result register parts the sides; a new request is taken while a result
//   waits, and only the final select cycle waits for the output slot to free.
// Reset: arst_n clears control state and loads the reset sizes and edge modes. The frame
//   store is not cleared; an unwritten pixel reads as whatever the RAM holds.
module pixel_art_2x_upscaler #(
	parameter int MAX_PIXELS = 4096,
	parameter int MAX_SIDE   = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	// stream in
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // [11:0] pixel_index, [43:12] pixel_value,
	                                    // [53:44] coord_x, [63:54] coord_y
	input  logic         s_axis_tuser,  // [0] cmd
	// stream out
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // [31:0] top_left, [63:32] top_right,
	                                    // [95:64] bottom_left, [127:96] bottom_right
	output logic         m_axis_tuser,  // [0] range_error
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [10:0]  cfg_data
);

	localparam int AW = $clog2(MAX_PIXELS);

	// ---------------- input unpacking ----------------
	logic [11:0] in_pixel_index;
	logic [31:0] in_pixel_value;
	logic [9:0]  in_coord_x;
	logic [9:0]  in_coord_y;
	logic        in_cmd;

	assign in_pixel_index = s_axis_tdata[11:0];
	assign in_pixel_value = s_axis_tdata[43:12];
	assign in_coord_x     = s_axis_tdata[53:44];
	assign in_coord_y     = s_axis_tdata[63:54];
	assign in_cmd         = s_axis_tuser;

	// ---------------- configuration ----------------
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic        clamp_h_q;
	logic        clamp_v_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= p2x_pkg::SIDE_RESET;
			height_q  <= p2x_pkg::SIDE_RESET;
			clamp_h_q <= 1'b0;
			clamp_v_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (p2x_pkg::cfg_idx_t'(cfg_index))
				p2x_pkg::CFG_IMAGE_WIDTH:  width_q   <= cfg_data;
				p2x_pkg::CFG_IMAGE_HEIGHT: height_q  <= cfg_data;
				p2x_pkg::CFG_CLAMP_HORIZ:  clamp_h_q <= cfg_data[0];
				p2x_pkg::CFG_CLAMP_VERT:   clamp_v_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- control ----------------
	p2x_pkg::state_t state_q;
	logic [3:0]      cnt_q;        // window pixel being addressed, row-major
	logic [10:0]     x_q;
	logic [10:0]     y_q;
	logic            err_q;
	logic            out_valid_q;
	logic            out_free;

	logic            in_fire;
	logic            wr_fire;
	logic [21:0]     area;
	logic            range_bad;

	assign s_axis_tready = (state_q == p2x_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign area      = width_q * height_q;
	assign range_bad = (width_q == 11'd0) || (height_q == 11'd0) ||
		(32'(width_q) > MAX_SIDE) || (32'(height_q) > MAX_SIDE) ||
		(32'(area) > MAX_PIXELS) ||
		({1'b0, in_coord_x} >= width_q) || ({1'b0, in_coord_y} >= height_q);

	// ---------------- frame store access ----------------
	logic [31:0]   wr_addr_full;
	logic [AW-1:0] wr_addr;
	logic [10:0]   row_idx;
	logic [10:0]   col_idx;
	logic [21:0]   rd_addr_full;
	logic [AW-1:0] addr_s1;
	logic          valid_s1;
	logic [3:0]    idx_s1;
	logic          valid_s2;
	logic [3:0]    idx_s2;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_rdata;

	assign wr_addr_full = 32'(in_pixel_index);
	assign wr_addr      = wr_addr_full[AW-1:0];
	assign wr_fire      = in_fire && (in_cmd == p2x_pkg::CMD_WRITE) &&
		(wr_addr_full < 32'(MAX_PIXELS));

	// Row and column of the window pixel under the counter, with wrap or clamp
	assign row_idx = p2x_pkg::neighbour(y_q, cnt_q[3:2], height_q, clamp_v_q);
	assign col_idx = p2x_pkg::neighbour(x_q, cnt_q[1:0], width_q, clamp_h_q);
	// row < height and col < width with width*height within the store
	assign rd_addr_full = (row_idx * width_q) + {11'd0, col_idx};

	// Reads only run outside idle, writes only in idle, so the port never clashes
	assign ram_addr = valid_s1 ? addr_s1 : wr_addr;

	p2x_ram #(
		.WIDTH(32),
		.DEPTH(MAX_PIXELS)
	) u_frame_store (
		.clk  (clk),
		.we   (wr_fire),
		.addr (ram_addr),
		.wdata(in_pixel_value),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == p2x_pkg::ST_READ);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr_full[AW-1:0];
		idx_s1  <= cnt_q;
		idx_s2  <= idx_s1;
	end

	// 4x4 window, k[i][j] at i*4+j
	logic [31:0] nb_q [16];

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			nb_q[idx_s2] <= ram_rdata;
		end
	end

	logic [31:0] k00, k01, k02, k03, k10, k11, k12, k13;
	logic [31:0] k20, k21, k22, k23, k30, k31, k32;

	assign k00 = nb_q[0];
	assign k01 = nb_q[1];
	assign k02 = nb_q[2];
	assign k03 = nb_q[3];
	assign k10 = nb_q[4];
	assign k11 = nb_q[5];
	assign k12 = nb_q[6];
	assign k13 = nb_q[7];
	assign k20 = nb_q[8];
	assign k21 = nb_q[9];
	assign k22 = nb_q[10];
	assign k23 = nb_q[11];
	assign k30 = nb_q[12];
	assign k31 = nb_q[13];
	assign k32 = nb_q[14];

	// ---------------- evaluate: compares and averages ----------------
	p2x_pkg::eq_t eq;
	p2x_pkg::eq_t eq_q;
	logic [31:0]  avg_cr_q;
	logic [31:0]  avg_cd_q;
	logic [31:0]  avg_all_q;

	always_comb begin
		eq.ce  = (k11 == k22);
		eq.rd  = (k12 == k21);
		eq.cr  = (k11 == k12);
		eq.cd  = (k11 == k21);
		eq.de  = (k21 == k22);
		eq.re  = (k12 == k22);
		eq.c00 = (k11 == k00);
		eq.c01 = (k11 == k01);
		eq.c02 = (k11 == k02);
		eq.c10 = (k11 == k10);
		eq.c13 = (k11 == k13);
		eq.c20 = (k11 == k20);
		eq.c23 = (k11 == k23);
		eq.c31 = (k11 == k31);
		eq.c32 = (k11 == k32);
		eq.r01 = (k12 == k01);
		eq.r02 = (k12 == k02);
		eq.r03 = (k12 == k03);
		eq.r10 = (k12 == k10);
		eq.r13 = (k12 == k13);
		eq.r20 = (k12 == k20);
		eq.r23 = (k12 == k23);
		eq.r31 = (k12 == k31);
		eq.r32 = (k12 == k32);
		eq.d10 = (k21 == k10);
		eq.d20 = (k21 == k20);
		eq.d30 = (k21 == k30);
		eq.d32 = (k21 == k32);
	end

	always_ff @(posedge clk) begin
		if (state_q == p2x_pkg::ST_EVAL) begin
			eq_q      <= eq;
			avg_cr_q  <= p2x_pkg::avg2(k11, k12);
			avg_cd_q  <= p2x_pkg::avg2(k11, k21);
			avg_all_q <= p2x_pkg::avg4(k11, k12, k21, k22);
		end
	end

	// ---------------- select: pattern rules and voting ----------------
	logic signed [3:0] score;
	logic [31:0]       sel_tr;
	logic [31:0]       sel_bl;
	logic [31:0]       sel_br;

	assign score = p2x_pkg::vote(eq_q.c10, eq_q.r10, eq_q.c01, eq_q.r01)
		- p2x_pkg::vote(eq_q.r13, eq_q.c13, eq_q.r02, eq_q.c02)
		- p2x_pkg::vote(eq_q.r20, eq_q.c20, eq_q.r31, eq_q.c31)
		+ p2x_pkg::vote(eq_q.c23, eq_q.r23, eq_q.c32, eq_q.r32);

	always_comb begin
		sel_tr = avg_cr_q;
		sel_bl = avg_cd_q;
		sel_br = avg_all_q;
		if (eq_q.ce && !eq_q.rd) begin
			// diagonal runs through the centre
			if ((eq_q.c01 && eq_q.r23) ||
					(eq_q.cd && eq_q.c02 && !eq_q.r01 && eq_q.r03)) begin
				sel_tr = k11;
			end
			if ((eq_q.c10 && eq_q.d32) ||
					(eq_q.cr && eq_q.c20 && !eq_q.d10 && eq_q.d30)) begin
				sel_bl = k11;
			end
			sel_br = k11;
		end else if (eq_q.rd && !eq_q.ce) begin
			// anti-diagonal runs through right and lower pixels
			if ((eq_q.r02 && eq_q.c20) ||
					(eq_q.r01 && eq_q.re && !eq_q.c02 && eq_q.c00)) begin
				sel_tr = k12;
			end
			if ((eq_q.d20 && eq_q.c02) ||
					(eq_q.d10 && eq_q.de && !eq_q.c20 && eq_q.c00)) begin
				sel_bl = k21;
			end
			sel_br = k12;
		end else if (eq_q.ce && eq_q.rd) begin
			if (eq_q.cr) begin
				sel_tr = k11;
				sel_bl = k11;
				sel_br = k11;
			end else if (score > 4'sd0) begin
				sel_br = k11;
			end else if (score < 4'sd0) begin
				sel_br = k12;
			end
		end else begin
			if (eq_q.cd && eq_q.c02 && !eq_q.r01 && eq_q.r03) begin
				sel_tr = k11;
			end else if (eq_q.r01 && eq_q.re && !eq_q.c02 && eq_q.c00) begin
				sel_tr = k12;
			end
			if (eq_q.cr && eq_q.c20 && !eq_q.d10 && eq_q.d30) begin
				sel_bl = k11;
			end else if (eq_q.d10 && eq_q.de && !eq_q.c20 && eq_q.c00) begin
				sel_bl = k21;
			end
		end
	end

	// ---------------- state machine ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= p2x_pkg::ST_IDLE;
			cnt_q   <= 4'd0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				p2x_pkg::ST_IDLE: begin
					cnt_q <= 4'd0;
					if (in_fire && (in_cmd == p2x_pkg::CMD_PROCESS)) begin
						err_q   <= range_bad;
						state_q <= range_bad ? p2x_pkg::ST_FINISH : p2x_pkg::ST_READ;
					end
				end
				p2x_pkg::ST_READ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= p2x_pkg::ST_DRAIN;
					end
				end
				p2x_pkg::ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= p2x_pkg::ST_EVAL;
					end
				end
				p2x_pkg::ST_EVAL: begin
					state_q <= p2x_pkg::ST_FINISH;
				end
				p2x_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= p2x_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= p2x_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= {1'b0, in_coord_x};
			y_q <= {1'b0, in_coord_y};
		end
	end

	// ---------------- result register ----------------
	logic [31:0] out_tl_q;
	logic [31:0] out_tr_q;
	logic [31:0] out_bl_q;
	logic [31:0] out_br_q;
	logic        out_err_q;
	logic        load_out;

	assign load_out = (state_q == p2x_pkg::ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_err_q <= err_q;
			out_tl_q  <= err_q ? 32'd0 : k11;
			out_tr_q  <= err_q ? 32'd0 : sel_tr;
			out_bl_q  <= err_q ? 32'd0 : sel_bl;
			out_br_q  <= err_q ? 32'd0 : sel_br;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_br_q, out_bl_q, out_tr_q, out_tl_q};
	assign m_axis_tuser  = out_err_q;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the 2xSaI pixel-art upscaler: directed edge cases, then random traffic.
module testbench;

	// Store size and side limit the block is built with
	localparam int unsigned STORE_DEPTH    = 4096;
	localparam int unsigned SIDE_LIMIT     = 1024;
	// Quiet cycles before a configuration change or the final verdict; enough to cover
	// a process request still in flight
	localparam int unsigned SETTLE_CYCLES  = 32;
	// Cycles with no handshake on any channel before the run is declared hung
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	// Rough number of requests to send before the random traffic stops
	localparam int unsigned ITEM_TARGET    = 850;

	// 8888 averaging masks: keep bits and carry bits for halves and quarters
	localparam logic [31:0] HALF_KEEP     = 32'hFEFE_FEFE;
	localparam logic [31:0] HALF_CARRY    = 32'h0101_0101;
	localparam logic [31:0] QUARTER_KEEP  = 32'hFCFC_FCFC;
	localparam logic [31:0] QUARTER_CARRY = 32'h0303_0303;

	// One expected output tile
	typedef struct packed {
		logic [31:0] top_left;
		logic [31:0] top_right;
		logic [31:0] bottom_left;
		logic [31:0] bottom_right;
		logic        range_error;
	} upscale_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Request stream
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata  = '0;   // [11:0] pixel_index, [43:12] pixel_value,
	                                    // [53:44] coord_x, [63:54] coord_y
	logic         s_axis_tuser  = 1'b0; // [0] cmd

	// Result stream
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;         // [31:0] top_left, [63:32] top_right,
	                                    // [95:64] bottom_left, [127:96] bottom_right
	logic         m_axis_tuser;         // [0] range_error

	// Configuration channel
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	p2x_pkg::cfg_idx_t   cfg_index = p2x_pkg::CFG_IMAGE_WIDTH;
	logic [10:0]         cfg_data  = '0;

	// Shadow of the block's configuration, at reset values
	logic [10:0]  cfg_w   = 11'd64;
	logic [10:0]  cfg_h   = 11'd64;
	bit           clamp_x = 1'b0;
	bit           clamp_y = 1'b0;

	// Shadow of the frame store; written[] tracks which entries are defined
	logic [31:0]  mirror_store [STORE_DEPTH];
	bit           written      [STORE_DEPTH];

	// Tiles predicted but not yet returned, oldest first
	upscale_t     expected_tiles [$];

	int           fail_count = 0;
	int unsigned  items_sent = 0;
	bit           pace_on    = 1'b1;   // random idling on both sides
	int unsigned  sink_hold  = 0;

	// Colours for pixel writes: a handful per phase so that the pattern rules see
	// plenty of equal neighbours
	logic [31:0]  palette [4];
	int unsigned  palette_span = 3;

	pixel_art_2x_upscaler #(
		.MAX_PIXELS(STORE_DEPTH),
		.MAX_SIDE  (SIDE_LIMIT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Byte-wise mean of two pixels, low bit kept only where both have it
	function automatic logic [31:0] mean2(input logic [31:0] a, input logic [31:0] b);
		if (a == b)
			return a;
		return (((a & HALF_KEEP) >> 1) + ((b & HALF_KEEP) >> 1)) | (a & b & HALF_CARRY);
	endfunction

	// Byte-wise mean of four pixels, low two bits summed apart
	function automatic logic [31:0] mean4(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] hi;
		logic [31:0] lo;
		hi = ((a & QUARTER_KEEP) >> 2) + ((b & QUARTER_KEEP) >> 2) +
			((c & QUARTER_KEEP) >> 2) + ((d & QUARTER_KEEP) >> 2);
		lo = (((a & QUARTER_CARRY) + (b & QUARTER_CARRY) + (c & QUARTER_CARRY) +
			(d & QUARTER_CARRY)) >> 2) & QUARTER_CARRY;
		return hi | lo;
	endfunction

	// +1 leans to p, -1 to q, 0 undecided, judged by neighbours s and t
	function automatic int weigh(input logic [31:0] p, input logic [31:0] q,
			input logic [31:0] s, input logic [31:0] t);
		int np;
		int nq;
		int res;
		np  = 0;
		nq  = 0;
		res = 0;
		if (p == s) np++;
		else if (q == s) nq++;
		if (p == t) np++;
		else if (q == t) nq++;
		if (np <= 1) res++;
		if (nq <= 1) res--;
		return res;
	endfunction

	// Position of window tap k (offset k-1) along an axis of n pixels
	function automatic int unsigned axis_pick(input int unsigned pos, input int unsigned k,
			input int unsigned n, input bit clamp);
		int unsigned t;
		t = pos + k;
		if (clamp) begin
			if (t == 0)
				return 0;
			t = t - 1;
			return (t > n - 1) ? n - 1 : t;
		end
		return (pos + n - 1 + k) % n;
	endfunction

	// Sizes or coordinate outside what the store can hold
	function automatic bit size_fault(input int unsigned x, input int unsigned y);
		int unsigned w;
		int unsigned h;
		w = cfg_w;
		h = cfg_h;
		return w == 0 || h == 0 || w > SIDE_LIMIT || h > SIDE_LIMIT ||
			w * h > STORE_DEPTH || x >= w || y >= h;
	endfunction

	function automatic upscale_t predict_upscale(input int unsigned x, input int unsigned y);
		upscale_t    res;
		logic [31:0] nb [4][4];
		int unsigned col [4];
		int unsigned row [4];
		int unsigned addr;
		int unsigned i;
		int unsigned j;
		logic [31:0] c;
		logic [31:0] tr;
		logic [31:0] bl;
		logic [31:0] br;
		int          score;
		res = '0;
		if (size_fault(x, y)) begin
			res.range_error = 1'b1;
			return res;
		end
		for (i = 0; i < 4; i++) begin
			col[i] = axis_pick(x, i, cfg_w, clamp_x);
			row[i] = axis_pick(y, i, cfg_h, clamp_y);
		end
		for (i = 0; i < 4; i++) begin
			for (j = 0; j < 4; j++) begin
				addr     = row[i] * cfg_w + col[j];
				nb[i][j] = (addr < STORE_DEPTH) ? mirror_store[addr] : 32'd0;
			end
		end

		// c = centre, nb[1][2] = right, nb[2][1] = below, nb[2][2] = diagonal
		c = nb[1][1];
		if (c == nb[2][2] && nb[1][2] != nb[2][1]) begin
			// centre runs along the main diagonal
			if ((c == nb[0][1] && nb[1][2] == nb[2][3]) ||
					(c == nb[2][1] && c == nb[0][2] && nb[1][2] != nb[0][1] &&
					nb[1][2] == nb[0][3]))
				tr = c;
			else
				tr = mean2(c, nb[1][2]);
			if ((c == nb[1][0] && nb[2][1] == nb[3][2]) ||
					(c == nb[1][2] && c == nb[2][0] && nb[1][0] != nb[2][1] &&
					nb[2][1] == nb[3][0]))
				bl = c;
			else
				bl = mean2(c, nb[2][1]);
			br = c;
		end else if (nb[1][2] == nb[2][1] && c != nb[2][2]) begin
			// the anti-diagonal pair wins
			if ((nb[1][2] == nb[0][2] && c == nb[2][0]) ||
					(nb[1][2] == nb[0][1] && nb[1][2] == nb[2][2] && c != nb[0][2] &&
					c == nb[0][0]))
				tr = nb[1][2];
			else
				tr = mean2(c, nb[1][2]);
			if ((nb[2][1] == nb[2][0] && c == nb[0][2]) ||
					(nb[2][1] == nb[1][0] && nb[2][1] == nb[2][2] && c != nb[2][0] &&
					c == nb[0][0]))
				bl = nb[2][1];
			else
				bl = mean2(c, nb[2][1]);
			br = nb[1][2];
		end else if (c == nb[2][2] && nb[1][2] == nb[2][1]) begin
			if (c == nb[1][2]) begin
				// flat 2x2 block
				tr = c;
				bl = c;
				br = c;
			end else begin
				// both diagonals hold: vote over the outer ring
				tr    = mean2(c, nb[1][2]);
				bl    = mean2(c, nb[2][1]);
				score = weigh(c, nb[1][2], nb[1][0], nb[0][1]) -
					weigh(nb[1][2], c, nb[1][3], nb[0][2]) -
					weigh(nb[1][2], c, nb[2][0], nb[3][1]) +
					weigh(c, nb[1][2], nb[2][3], nb[3][2]);
				if (score > 0)
					br = c;
				else if (score < 0)
					br = nb[1][2];
				else
					br = mean4(c, nb[1][2], nb[2][1], nb[2][2]);
			end
		end else begin
			// no diagonal: blend, unless a local edge pattern picks a side
			br = mean4(c, nb[1][2], nb[2][1], nb[2][2]);
			if (c == nb[2][1] && c == nb[0][2] && nb[1][2] != nb[0][1] && nb[1][2] == nb[0][3])
				tr = c;
			else if (nb[1][2] == nb[0][1] && nb[1][2] == nb[2][2] && c != nb[0][2] &&
					c == nb[0][0])
				tr = nb[1][2];
			else
				tr = mean2(c, nb[1][2]);
			if (c == nb[1][2] && c == nb[2][0] && nb[1][0] != nb[2][1] && nb[2][1] == nb[3][0])
				bl = c;
			else if (nb[2][1] == nb[1][0] && nb[2][1] == nb[2][2] && c != nb[2][0] &&
					c == nb[0][0])
				bl = nb[2][1];
			else
				bl = mean2(c, nb[2][1]);
		end

		res.top_left     = c;
		res.top_right    = tr;
		res.bottom_left  = bl;
		res.bottom_right = br;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Pacing
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 15)
			return $urandom_range(1, 3);
		if (roll < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned request_gap();
		if (!pace_on || $urandom_range(0, 2) != 0)
			return 0;
		return pick_gap();
	endfunction

	function automatic logic [31:0] fresh_colour();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return palette[$urandom_range(0, palette_span)];
	endfunction

	// Result side back-pressure: stalls of random length while pacing is on
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold     <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (pace_on && $urandom_range(0, 3) == 0) begin
			sink_hold     <= pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result checking: every result against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		upscale_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tiles.size() == 0) begin
				$error("unexpected result: tdata %h, tuser %b", m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = expected_tiles.pop_front();
				if (m_axis_tdata[31:0] !== want.top_left) begin
					$error("top_left: expected %h, got %h", want.top_left, m_axis_tdata[31:0]);
					fail_count++;
				end
				if (m_axis_tdata[63:32] !== want.top_right) begin
					$error("top_right: expected %h, got %h", want.top_right,
						m_axis_tdata[63:32]);
					fail_count++;
				end
				if (m_axis_tdata[95:64] !== want.bottom_left) begin
					$error("bottom_left: expected %h, got %h", want.bottom_left,
						m_axis_tdata[95:64]);
					fail_count++;
				end
				if (m_axis_tdata[127:96] !== want.bottom_right) begin
					$error("bottom_right: expected %h, got %h", want.bottom_right,
						m_axis_tdata[127:96]);
					fail_count++;
				end
				if (m_axis_tuser !== want.range_error) begin
					$error("range_error: expected %b, got %b", want.range_error, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// Hang detection: any handshake on any channel restarts the count
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request and register drivers
	// ------------------------------------------------------------------

	// Sends one request; on acceptance the shadow store or the expected
	// tiles are updated. tvalid stays high after acceptance so that a
	// back-to-back request needs no second assignment in the same step.
	task automatic send_request(input logic cmd, input logic [11:0] idx,
			input logic [31:0] val, input logic [9:0] x, input logic [9:0] y);
		int unsigned gap;
		gap = request_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {y, x, val, idx};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		if (cmd == p2x_pkg::CMD_WRITE) begin
			mirror_store[idx] = val;
			written[idx]      = 1'b1;
		end else begin
			expected_tiles.push_back(predict_upscale(x, y));
		end
		items_sent++;
	endtask

	task automatic issue_write(input logic [11:0] idx, input logic [31:0] val);
		send_request(p2x_pkg::CMD_WRITE, idx, val, 10'($urandom_range(0, 1023)),
			10'($urandom_range(0, 1023)));
	endtask

	// Process request; a valid coordinate first gets every window pixel
	// defined, since unwritten store entries must never be read
	task automatic issue_process(input int unsigned x, input int unsigned y);
		int unsigned i;
		int unsigned j;
		int unsigned addr;
		if (!size_fault(x, y)) begin
			for (i = 0; i < 4; i++) begin
				for (j = 0; j < 4; j++) begin
					addr = axis_pick(y, i, cfg_h, clamp_y) * cfg_w +
						axis_pick(x, j, cfg_w, clamp_x);
					if (!written[addr])
						issue_write(12'(addr), fresh_colour());
				end
			end
		end
		send_request(p2x_pkg::CMD_PROCESS, 12'($urandom_range(0, 4095)), $urandom,
			10'(x), 10'(y));
	endtask

	// Drop tvalid, let every outstanding result come back, then allow for a
	// request still in the pipe before the block is treated as idle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_tiles.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input p2x_pkg::cfg_idx_t which, input logic [10:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (which)
			p2x_pkg::CFG_IMAGE_WIDTH:  cfg_w   = value;
			p2x_pkg::CFG_IMAGE_HEIGHT: cfg_h   = value;
			p2x_pkg::CFG_CLAMP_HORIZ:  clamp_x = value[0];
			p2x_pkg::CFG_CLAMP_VERT:   clamp_y = value[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Edge-mode registers only look at bit 0; the rest carries noise
	task automatic set_geometry(input int unsigned w, input int unsigned h,
			input bit cx, input bit cy);
		logic [10:0] noise;
		settle();
		noise = 11'($urandom_range(0, 2047));
		write_register(p2x_pkg::CFG_IMAGE_WIDTH, 11'(w));
		write_register(p2x_pkg::CFG_IMAGE_HEIGHT, 11'(h));
		write_register(p2x_pkg::CFG_CLAMP_HORIZ, {noise[10:1], cx});
		noise = 11'($urandom_range(0, 2047));
		write_register(p2x_pkg::CFG_CLAMP_VERT, {noise[10:1], cy});
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset sizes are 64x64: coordinates on or past them are flagged
	task automatic test_reset_sizes();
		issue_process(64, 0);
		issue_process(0, 64);
		issue_process(1023, 1023);
	endtask

	// Zero sides, sides past the limit and too many pixels all flag an error
	task automatic test_size_faults();
		set_geometry(0, 4, 1'b0, 1'b0);
		issue_process(0, 0);
		set_geometry(4, 0, 1'b0, 1'b0);
		issue_process(0, 0);
		set_geometry(1025, 1, 1'b0, 1'b1);
		issue_process(0, 0);
		set_geometry(2047, 2047, 1'b1, 1'b1);
		issue_process(0, 0);
		set_geometry(128, 64, 1'b1, 1'b0);
		issue_process(5, 5);
	endtask

	// A single-pixel image: every tap is the centre under either edge mode
	task automatic test_single_pixel();
		set_geometry(1, 1, 1'b0, 1'b0);
		issue_write(12'd0, $urandom);
		issue_process(0, 0);
		set_geometry(1, 1, 1'b1, 1'b1);
		issue_process(0, 0);
	endtask

	// 2x2 image of random pixels, the corners (0,0) and (1,1) under every combination of edge modes
	task automatic test_edge_modes();
		int unsigned mode;
		set_geometry(2, 2, 1'b0, 1'b0);
		for (mode = 0; mode < 4; mode++)
			issue_write(12'(mode), $urandom);
		for (mode = 0; mode < 4; mode++) begin
			set_geometry(2, 2, mode[0], mode[1]);
			issue_process(0, 0);
			issue_process(1, 1);
		end
	endtask

	// Coordinate along a side: edges favoured, anything when the side is bad
	function automatic int unsigned pick_coord(input int unsigned n);
		if (n == 0 || n > SIDE_LIMIT)
			return $urandom_range(0, 1023);
		if ($urandom_range(0, 9) < 3)
			return $urandom_range(0, 1) ? n - 1 : 0;
		return $urandom_range(0, n - 1);
	endfunction

	// One phase: new geometry, new palette, then a mix of requests
	task automatic run_random_phase();
		int unsigned w;
		int unsigned h;
		int unsigned ops;
		int unsigned n;
		int unsigned roll;
		roll = $urandom_range(0, 11);
		case (roll)
			0: begin
				w = 1024;
				h = $urandom_range(1, 4);
			end
			1: begin
				w = $urandom_range(1, 4);
				h = 1024;
			end
			2: begin
				w = 64;
				h = 64;
			end
			3: begin
				// side zero or past the limit
				w = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
				h = $urandom_range(0, 2047);
			end
			4: begin
				// both sides legal, product too large
				w = $urandom_range(65, 1024);
				h = 4096 / w + $urandom_range(1, 8);
			end
			default: begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 8);
			end
		endcase

		pace_on = ($urandom_range(0, 3) != 0);
		for (n = 0; n < 4; n++)
			palette[n] = $urandom;
		if ($urandom_range(0, 3) == 0)
			palette[0] = 32'h0000_0000;
		if ($urandom_range(0, 3) == 0)
			palette[1] = 32'hFFFF_FFFF;
		palette_span = $urandom_range(1, 3);

		set_geometry(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		// big images cost up to 16 fills per window, so keep those phases short
		ops = (w * h > 256) ? 10 : $urandom_range(40, 80);

		for (n = 0; n < ops && items_sent < ITEM_TARGET; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 65)
				issue_process(pick_coord(w), pick_coord(h));
			else if (roll < 75)
				issue_process($urandom_range(0, 1023), $urandom_range(0, 1023));
			else if (roll < 95)
				issue_write(12'((w * h >= 1 && w * h <= STORE_DEPTH) ?
					$urandom_range(0, w * h - 1) : $urandom_range(0, 4095)), fresh_colour());
			else
				issue_write(12'($urandom_range(0, 4095)), $urandom);
		end
	endtask

	task automatic test_random_traffic();
		while (items_sent < ITEM_TARGET)
			run_random_phase();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		palette[0] = 32'h0000_0000;
		palette[1] = 32'hFFFF_FFFF;
		palette[2] = 32'h8040_20FF;
		palette[3] = 32'h0101_0101;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_size_faults();
		test_single_pixel();
		test_edge_modes();
		test_random_traffic();

		settle();
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
